/* rtl/core/tccw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

  localparam int SCREEN_ROWS = 25;
  localparam int SCREEN_COLS = 80;
  localparam int TAB_STOP    = 8;
  localparam int CELL_COUNT  = SCREEN_ROWS * SCREEN_COLS;
  localparam int COPY_COUNT  = SCREEN_COLS * (SCREEN_ROWS - 1);

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int CNT_W  = $clog2(TAB_STOP + 1);

  localparam logic [15:0] BLANK_CELL = 16'h0700;

  localparam logic [2:0] OP_PUT     = 3'd0;
  localparam logic [2:0] OP_GOTO    = 3'd1;
  localparam logic [2:0] OP_CLEAR   = 3'd2;
  localparam logic [2:0] OP_CLR_EOL = 3'd3;
  localparam logic [2:0] OP_CLR_EOS = 3'd4;
  localparam logic [2:0] OP_READ    = 3'd5;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef logic [3:0] cmd_t;

  localparam cmd_t CMD_NOP     = 4'd0;
  localparam cmd_t CMD_GLYPH   = 4'd1;
  localparam cmd_t CMD_TAB     = 4'd2;
  localparam cmd_t CMD_CR      = 4'd3;
  localparam cmd_t CMD_LF      = 4'd4;
  localparam cmd_t CMD_BS      = 4'd5;
  localparam cmd_t CMD_GOTO    = 4'd6;
  localparam cmd_t CMD_CLEAR   = 4'd7;
  localparam cmd_t CMD_CLR_EOL = 4'd8;
  localparam cmd_t CMD_CLR_EOS = 4'd9;
  localparam cmd_t CMD_READ    = 4'd10;

  typedef struct packed {
    cmd_t              cmd;
    logic [7:0]        ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              in_range;
    logic [ADDR_W-1:0] addr;
  } item_t;

  typedef struct packed {
    logic [3:0] fg;
    logic [3:0] bg;
    logic       raw;
    logic       cursor_en;
  } cfg_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

endpackage

`default_nettype wire

/* rtl/core/text_console_char_writer_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Text console engine for an 80x25 screen of 16-bit cells.
// Commands enter on start with opcode, char_code, target_col and target_row;
// a command is taken when start is high and busy is low. A two-entry queue
// decouples command intake from the execution sequencer, so busy only rises
// when both entries are full or while the screen is blanked after reset.
// Each command produces one result beat: done is high for a single cycle with
// the cursor position, cursor offset, scroll count and read cell word. The
// receiver must take every beat; there is no way to hold results back.
// A plain character passes through the dispatch and cell-write steps of the
// sequencer, which is built around the single write port of the screen
// memory; the next command is dispatched only after the cell write.
// A tab writes spaces up to the next tab stop, one per cell-write step.
// A scroll walks the memory one cell a cycle, moving each row up and then
// blanking the bottom row. Clear screen and clear to end of screen blank one
// cell a cycle. After reset the screen memory is filled with blank cells while
// busy stays high; the APB registers can be written during that pass.
// APB registers: 0x0 foreground, 0x4 background, 0x8 raw mode, 0xC cursor
// enable. Change them only while no command is outstanding.

module text_console_char_writer_core
  import tccw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        opcode,
  input  wire logic [7:0]        char_code,
  input  wire logic [COL_W-1:0]  target_col,
  input  wire logic [ROW_W-1:0]  target_row,
  output logic                   done,
  output logic [COL_W-1:0]       cursor_col,
  output logic [ROW_W-1:0]       cursor_row,
  output logic                   cursor_visible,
  output logic [ADDR_W-1:0]      cursor_offset,
  output logic [31:0]            scroll_count,
  output logic [15:0]            cell_word
);

  localparam logic [1:0] REG_FG     = 2'd0;
  localparam logic [1:0] REG_BG     = 2'd1;
  localparam logic [1:0] REG_RAW    = 2'd2;
  localparam logic [1:0] REG_CURSOR = 2'd3;

  cfg_t       cfg;
  back_stat_t stat;
  logic       q_valid;
  item_t      q_head;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fg        <= 4'd7;
      cfg.bg        <= 4'd0;
      cfg.raw       <= 1'b0;
      cfg.cursor_en <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_FG:     cfg.fg        <= pwdata[3:0];
        REG_BG:     cfg.bg        <= pwdata[3:0];
        REG_RAW:    cfg.raw       <= pwdata[0];
        REG_CURSOR: cfg.cursor_en <= pwdata[0];
        default:    cfg.fg        <= cfg.fg;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FG:     prdata = {28'd0, cfg.fg};
      REG_BG:     prdata = {28'd0, cfg.bg};
      REG_RAW:    prdata = {31'd0, cfg.raw};
      REG_CURSOR: prdata = {31'd0, cfg.cursor_en};
      default:    prdata = '0;
    endcase
  end

  tccw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .opcode     (opcode),
    .char_code  (char_code),
    .target_col (target_col),
    .target_row (target_row),
    .cfg        (cfg),
    .stat       (stat),
    .busy       (busy),
    .q_valid    (q_valid),
    .q_head     (q_head)
  );

  tccw_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .cfg            (cfg),
    .stat           (stat),
    .done           (done),
    .cursor_col     (cursor_col),
    .cursor_row     (cursor_row),
    .cursor_visible (cursor_visible),
    .cursor_offset  (cursor_offset),
    .scroll_count   (scroll_count),
    .cell_word      (cell_word)
  );

endmodule

`default_nettype wire

/* rtl/core/tccw_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tccw_front
  import tccw_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [2:0]       opcode,
  input  wire logic [7:0]       char_code,
  input  wire logic [COL_W-1:0] target_col,
  input  wire logic [ROW_W-1:0] target_row,
  input  wire cfg_t             cfg,
  input  wire back_stat_t       stat,
  output logic                  busy,
  output logic                  q_valid,
  output item_t                 q_head
);

  item_t      item;
  item_t      q [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       push;

  always_comb begin
    item          = '0;
    item.ch       = char_code;
    item.col      = target_col;
    item.row      = target_row;
    item.in_range = (target_col < COL_W'(SCREEN_COLS)) && (target_row < ROW_W'(SCREEN_ROWS));
    item.addr     = ADDR_W'(target_row * SCREEN_COLS) + ADDR_W'(target_col);
    unique case (opcode)
      OP_PUT: begin
        if (cfg.raw) begin
          item.cmd = CMD_GLYPH;
        end else begin
          case (char_code)
            CH_TAB:  item.cmd = CMD_TAB;
            CH_CR:   item.cmd = CMD_CR;
            CH_LF:   item.cmd = CMD_LF;
            CH_BS:   item.cmd = CMD_BS;
            default: item.cmd = CMD_GLYPH;
          endcase
        end
      end
      OP_GOTO:    item.cmd = CMD_GOTO;
      OP_CLEAR:   item.cmd = CMD_CLEAR;
      OP_CLR_EOL: item.cmd = CMD_CLR_EOL;
      OP_CLR_EOS: item.cmd = CMD_CLR_EOS;
      OP_READ:    item.cmd = CMD_READ;
      default:    item.cmd = CMD_NOP;
    endcase
  end

  // Items are held off while the screen is being blanked after reset.
  assign busy    = (count == 2'd2) || stat.clearing;
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_head  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (stat.pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(stat.pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tccw_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module tccw_back
  import tccw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire item_t             q_head,
  input  wire cfg_t              cfg,
  output back_stat_t             stat,
  output logic                   done,
  output logic [COL_W-1:0]       cursor_col,
  output logic [ROW_W-1:0]       cursor_row,
  output logic                   cursor_visible,
  output logic [ADDR_W-1:0]      cursor_offset,
  output logic [31:0]            scroll_count,
  output logic [15:0]            cell_word
);

  localparam logic [2:0] S_IDLE        = 3'd0;
  localparam logic [2:0] S_DRAW        = 3'd1;
  localparam logic [2:0] S_SCROLL      = 3'd2;
  localparam logic [2:0] S_SCROLL_TAIL = 3'd3;
  localparam logic [2:0] S_FILL        = 3'd4;
  localparam logic [2:0] S_READ        = 3'd5;

  localparam logic [1:0] RET_NONE   = 2'd0;
  localparam logic [1:0] RET_RESULT = 2'd1;
  localparam logic [1:0] RET_DRAW   = 2'd2;

  logic [15:0] mem [CELL_COUNT];
  logic [15:0] rd_data;

  logic [2:0]        state, state_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [31:0]       scroll_total, scroll_total_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic [ADDR_W-1:0] fill_end, fill_end_next;
  logic [ADDR_W-1:0] scr_idx, scr_idx_next;
  logic              cp_wr, cp_wr_next;
  logic [ADDR_W-1:0] cp_addr, cp_addr_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [1:0]        ret, ret_next;
  logic [7:0]        ch, ch_next;
  logic              rd_ok, rd_ok_next;

  logic              finish;
  logic [15:0]       cell_res;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [15:0]       wdata;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] here;
  logic [ADDR_W-1:0] row_end;
  logic              wrap;
  logic              last_row;

  assign here     = ADDR_W'(row * SCREEN_COLS) + ADDR_W'(col);
  assign row_end  = ADDR_W'((row + 1) * SCREEN_COLS);
  assign wrap     = (col == COL_W'(SCREEN_COLS));
  assign last_row = (row >= ROW_W'(SCREEN_ROWS - 1));

  always_comb begin
    state_next        = state;
    col_next          = col;
    row_next          = row;
    scroll_total_next = scroll_total;
    ptr_next          = ptr;
    fill_end_next     = fill_end;
    scr_idx_next      = scr_idx;
    cp_wr_next        = 1'b0;
    cp_addr_next      = cp_addr;
    cnt_next          = cnt;
    ret_next          = ret;
    ch_next           = ch;
    rd_ok_next        = rd_ok;
    finish            = 1'b0;
    cell_res          = '0;
    stat.pop          = 1'b0;
    stat.clearing     = (state == S_FILL) && (ret == RET_NONE);
    raddr             = q_head.addr;
    we                = 1'b0;
    waddr             = ptr;
    wdata             = BLANK_CELL;

    // The delayed write of a scroll copy owns the write port when pending.
    if (cp_wr) begin
      we    = 1'b1;
      waddr = cp_addr;
      wdata = rd_data;
    end

    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          stat.pop = 1'b1;
          case (q_head.cmd)
            CMD_GLYPH: begin
              ch_next    = q_head.ch;
              cnt_next   = CNT_W'(1);
              state_next = S_DRAW;
            end
            CMD_TAB: begin
              ch_next    = CH_SPACE;
              cnt_next   = CNT_W'(TAB_STOP - (col % TAB_STOP));
              state_next = S_DRAW;
            end
            CMD_CR: begin
              col_next = '0;
              finish   = 1'b1;
            end
            CMD_LF: begin
              if (last_row) begin
                scroll_total_next = scroll_total + 32'd1;
                scr_idx_next      = '0;
                ret_next          = RET_RESULT;
                state_next        = S_SCROLL;
              end else begin
                row_next = row + ROW_W'(1);
                finish   = 1'b1;
              end
            end
            CMD_BS: begin
              if (col != '0) begin
                col_next = col - COL_W'(1);
              end else if (row != '0) begin
                row_next = row - ROW_W'(1);
                col_next = COL_W'(SCREEN_COLS - 1);
              end
              finish = 1'b1;
            end
            CMD_GOTO: begin
              if (q_head.in_range) begin
                col_next = q_head.col;
                row_next = q_head.row;
              end
              finish = 1'b1;
            end
            CMD_CLEAR: begin
              col_next      = '0;
              row_next      = '0;
              ptr_next      = '0;
              fill_end_next = ADDR_W'(CELL_COUNT);
              ret_next      = RET_RESULT;
              state_next    = S_FILL;
            end
            CMD_CLR_EOL: begin
              if (here < row_end) begin
                ptr_next      = here;
                fill_end_next = row_end;
                ret_next      = RET_RESULT;
                state_next    = S_FILL;
              end else begin
                finish = 1'b1;
              end
            end
            CMD_CLR_EOS: begin
              if (here < ADDR_W'(CELL_COUNT)) begin
                ptr_next      = here;
                fill_end_next = ADDR_W'(CELL_COUNT);
                ret_next      = RET_RESULT;
                state_next    = S_FILL;
              end else begin
                finish = 1'b1;
              end
            end
            CMD_READ: begin
              rd_ok_next = q_head.in_range;
              state_next = S_READ;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end

      S_DRAW: begin
        if (wrap && last_row) begin
          // Wrap off the bottom row: scroll first, then draw at column zero.
          col_next          = '0;
          scroll_total_next = scroll_total + 32'd1;
          scr_idx_next      = '0;
          ret_next          = RET_DRAW;
          state_next        = S_SCROLL;
        end else begin
          we       = 1'b1;
          waddr    = wrap ? row_end : here;
          wdata    = {cfg.bg, cfg.fg, ch};
          row_next = wrap ? row + ROW_W'(1) : row;
          col_next = wrap ? COL_W'(1) : col + COL_W'(1);
          cnt_next = cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            finish     = 1'b1;
            state_next = S_IDLE;
          end
        end
      end

      S_SCROLL: begin
        raddr        = scr_idx + ADDR_W'(SCREEN_COLS);
        cp_wr_next   = 1'b1;
        cp_addr_next = scr_idx;
        if (scr_idx == ADDR_W'(COPY_COUNT - 1)) begin
          state_next = S_SCROLL_TAIL;
        end else begin
          scr_idx_next = scr_idx + ADDR_W'(1);
        end
      end

      S_SCROLL_TAIL: begin
        ptr_next      = ADDR_W'(COPY_COUNT);
        fill_end_next = ADDR_W'(CELL_COUNT);
        state_next    = S_FILL;
      end

      S_FILL: begin
        we       = 1'b1;
        waddr    = ptr;
        wdata    = BLANK_CELL;
        ptr_next = ptr + ADDR_W'(1);
        if (ptr == fill_end - ADDR_W'(1)) begin
          case (ret)
            RET_RESULT: begin
              finish     = 1'b1;
              state_next = S_IDLE;
            end
            RET_DRAW: state_next = S_DRAW;
            default:  state_next = S_IDLE;
          endcase
        end
      end

      S_READ: begin
        cell_res   = rd_ok ? rd_data : 16'h0000;
        finish     = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_FILL;
      col          <= '0;
      row          <= '0;
      scroll_total <= '0;
      ptr          <= '0;
      fill_end     <= ADDR_W'(CELL_COUNT);
      scr_idx      <= '0;
      cp_wr        <= 1'b0;
      cnt          <= '0;
      ret          <= RET_NONE;
      rd_ok        <= 1'b0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      col          <= col_next;
      row          <= row_next;
      scroll_total <= scroll_total_next;
      ptr          <= ptr_next;
      fill_end     <= fill_end_next;
      scr_idx      <= scr_idx_next;
      cp_wr        <= cp_wr_next;
      cnt          <= cnt_next;
      ret          <= ret_next;
      rd_ok        <= rd_ok_next;
      done         <= finish;
    end
  end

  always_ff @(posedge clk) begin
    cp_addr <= cp_addr_next;
    ch      <= ch_next;
    if (finish) begin
      cursor_col     <= col_next;
      cursor_row     <= row_next;
      cursor_visible <= cfg.cursor_en;
      cursor_offset  <= ADDR_W'(row_next * SCREEN_COLS) + ADDR_W'(col_next);
      scroll_count   <= scroll_total_next;
      cell_word      <= cell_res;
    end
  end

endmodule

`default_nettype wire
